>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the formatter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/fdnf_pkg.sv
// Package with the constants, codes, stage types and helpers of the formatter.
package fdnf_pkg;

    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int MAG_W   = 32;
    localparam int SCALE_W = 10;
    localparam int PROD_W  = MAG_W + SCALE_W;
    localparam int VAL_W   = 14;
    localparam int DIG_W   = 8;
    localparam int NUM_W   = 4;
    localparam int Q1_W    = 10;
    localparam int Q2_W    = 7;
    localparam int Q3_W    = 4;
    localparam int RECIP_W = 30;

    localparam int INT_MAX     = 9999;
    localparam int INT_NEG_MAX = 999;

    localparam logic [DIG_W-1:0] CODE_MINUS = 8'h0A;
    localparam logic [DIG_W-1:0] CODE_BLANK = 8'hFF;

    // Reciprocals for exact division of values below 16384 by 10, 100 and 1000.
    localparam logic [RECIP_W-1:0] RECIP_10     = 30'd52429;
    localparam int                 SHIFT_10     = 19;
    localparam logic [RECIP_W-1:0] RECIP_100    = 30'd5243;
    localparam int                 SHIFT_100    = 19;
    localparam logic [RECIP_W-1:0] RECIP_1000   = 30'd16778;
    localparam int                 SHIFT_1000   = 24;

    typedef struct packed {
        logic               frac;
        logic               neg;
        logic [MAG_W-1:0]   mag;
        logic [SCALE_W-1:0] scale;
        logic [3:0]         mask;
    } cls_t;

    typedef struct packed {
        logic              frac;
        logic              neg;
        logic [PROD_W-1:0] val;
        logic [3:0]        mask;
    } prod_t;

    typedef struct packed {
        logic             frac;
        logic             neg;
        logic [VAL_W-1:0] value;
        logic [Q1_W-1:0]  q1;
        logic [Q2_W-1:0]  q2;
        logic [Q3_W-1:0]  q3;
        logic [3:0]       mask;
    } quot_t;

    typedef struct packed {
        logic [NUM_W-1:0][DIG_W-1:0] digit;
        logic [3:0]                  mask;
    } res_t;

    function automatic logic [SCALE_W-1:0] pow10(input logic [1:0] places);
        logic [SCALE_W-1:0] s;
        case (places)
            2'd1:    s = 10'd10;
            2'd2:    s = 10'd100;
            2'd3:    s = 10'd1000;
            default: s = 10'd1;
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/fdnf_classify.sv
// Mode decode, saturation, magnitude and decimal place count for one value.
module fdnf_classify #(
    parameter int FRACTION_BITS = fdnf_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                req_type,
    input  logic signed [31:0]  number,
    output fdnf_pkg::cls_t      cls
);

    logic [31:0] raw;
    logic [31:0] mag_abs;
    logic [31:0] ip;
    logic [2:0]  idig;
    logic [2:0]  room;
    logic [1:0]  places;

    always_comb
    begin
        raw     = number;
        mag_abs = raw[31] ? (~raw + 32'd1) : raw;
        ip      = mag_abs >> FRACTION_BITS;

        if (ip < 32'd10)
        begin
            idig = 3'd1;
        end
        else if (ip < 32'd100)
        begin
            idig = 3'd2;
        end
        else if (ip < 32'd1000)
        begin
            idig = 3'd3;
        end
        else
        begin
            idig = 3'd4;
        end
        room   = idig + {2'b00, raw[31]};
        places = 2'(3'd4 - room);

        cls.frac  = 1'b0;
        cls.neg   = raw[31];
        cls.mag   = mag_abs;
        cls.scale = fdnf_pkg::pow10(2'd0);
        cls.mask  = 4'b0000;

        if (!req_type)
        begin
            if (number > fdnf_pkg::INT_MAX)
            begin
                cls.neg = 1'b0;
                cls.mag = 32'(fdnf_pkg::INT_MAX);
            end
            else if (number < -fdnf_pkg::INT_NEG_MAX)
            begin
                cls.neg = 1'b1;
                cls.mag = 32'(fdnf_pkg::INT_NEG_MAX);
            end
        end
        else if (raw[31] && ip > 32'(fdnf_pkg::INT_NEG_MAX))
        begin
            cls.mag = 32'(fdnf_pkg::INT_NEG_MAX);
        end
        else if (ip > 32'(fdnf_pkg::INT_MAX))
        begin
            cls.mag = 32'(fdnf_pkg::INT_MAX);
        end
        else if (room >= 3'd4)
        begin
            cls.mag = ip;
        end
        else
        begin
            cls.frac  = 1'b1;
            cls.scale = fdnf_pkg::pow10(places);
            cls.mask  = 4'b1000 >> places;
        end
    end

endmodule

>>> hw/rtl/fdnf_scale.sv
// In fraction mode, scales the magnitude by the power of ten and adds the rounding half.
module fdnf_scale #(
    parameter int FRACTION_BITS = fdnf_pkg::FRACTION_BITS_DEFAULT
) (
    input  fdnf_pkg::cls_t  cls,
    output fdnf_pkg::prod_t prod
);

    localparam logic [fdnf_pkg::PROD_W-1:0] HALF =
        fdnf_pkg::PROD_W'(1) << (FRACTION_BITS - 1);

    logic [fdnf_pkg::PROD_W-1:0] product;

    always_comb
    begin
        product   = fdnf_pkg::PROD_W'(cls.mag) * fdnf_pkg::PROD_W'(cls.scale);
        prod.frac = cls.frac;
        prod.neg  = cls.neg;
        prod.mask = cls.mask;
        prod.val  = cls.frac ? (product + HALF) : fdnf_pkg::PROD_W'(cls.mag);
    end

endmodule

>>> hw/rtl/fdnf_split.sv
// Drops the fraction bits in fraction mode and forms the quotients by 10, 100 and 1000.
module fdnf_split #(
    parameter int FRACTION_BITS = fdnf_pkg::FRACTION_BITS_DEFAULT
) (
    input  fdnf_pkg::prod_t prod,
    output fdnf_pkg::quot_t quot
);

    logic [fdnf_pkg::VAL_W-1:0]   value;
    logic [fdnf_pkg::RECIP_W-1:0] p10;
    logic [fdnf_pkg::RECIP_W-1:0] p100;
    logic [fdnf_pkg::RECIP_W-1:0] p1000;

    always_comb
    begin
        if (prod.frac)
        begin
            value = fdnf_pkg::VAL_W'(prod.val >> FRACTION_BITS);
        end
        else
        begin
            value = prod.val[fdnf_pkg::VAL_W-1:0];
        end
        p10   = fdnf_pkg::RECIP_W'(value) * fdnf_pkg::RECIP_10;
        p100  = fdnf_pkg::RECIP_W'(value) * fdnf_pkg::RECIP_100;
        p1000 = fdnf_pkg::RECIP_W'(value) * fdnf_pkg::RECIP_1000;

        quot.frac  = prod.frac;
        quot.neg   = prod.neg;
        quot.mask  = prod.mask;
        quot.value = value;
        quot.q1    = fdnf_pkg::Q1_W'(p10 >> fdnf_pkg::SHIFT_10);
        quot.q2    = fdnf_pkg::Q2_W'(p100 >> fdnf_pkg::SHIFT_100);
        quot.q3    = fdnf_pkg::Q3_W'(p1000 >> fdnf_pkg::SHIFT_1000);
    end

endmodule

>>> hw/rtl/fdnf_layout.sv
// Turns the quotients into digit codes and places blanks, sign and point.
module fdnf_layout (
    input  fdnf_pkg::quot_t quot,
    output fdnf_pkg::res_t  res
);

    logic [fdnf_pkg::VAL_W-1:0] ten1;
    logic [fdnf_pkg::Q1_W-1:0]  ten2;
    logic [fdnf_pkg::Q2_W-1:0]  ten3;
    logic [3:0]                 dig0;
    logic [3:0]                 dig1;
    logic [3:0]                 dig2;
    logic [3:0]                 dig3;
    logic                       ge10;
    logic                       ge100;
    logic                       ge1000;

    always_comb
    begin
        ten1 = (fdnf_pkg::VAL_W'(quot.q1) << 3) + (fdnf_pkg::VAL_W'(quot.q1) << 1);
        ten2 = (fdnf_pkg::Q1_W'(quot.q2) << 3) + (fdnf_pkg::Q1_W'(quot.q2) << 1);
        ten3 = (fdnf_pkg::Q2_W'(quot.q3) << 3) + (fdnf_pkg::Q2_W'(quot.q3) << 1);
        dig3 = 4'(quot.value - ten1);
        dig2 = 4'(quot.q1 - ten2);
        dig1 = 4'(quot.q2 - ten3);
        // A rounding carry into a fifth digit leaves only the low four shown.
        dig0 = (quot.q3 == 4'd10) ? 4'd0 : quot.q3;

        ge10   = quot.value >= 14'd10;
        ge100  = quot.value >= 14'd100;
        ge1000 = quot.value >= 14'd1000;

        res.digit[3] = {4'b0000, dig3};
        if (quot.frac)
        begin
            res.digit[2] = {4'b0000, dig2};
            res.digit[1] = {4'b0000, dig1};
            res.digit[0] = quot.neg ? fdnf_pkg::CODE_MINUS : {4'b0000, dig0};
            res.mask     = quot.mask;
        end
        else
        begin
            res.mask = 4'b0000;
            if (ge10)
            begin
                res.digit[2] = {4'b0000, dig2};
            end
            else
            begin
                res.digit[2] = quot.neg ? fdnf_pkg::CODE_MINUS : fdnf_pkg::CODE_BLANK;
            end
            if (ge100)
            begin
                res.digit[1] = {4'b0000, dig1};
            end
            else
            begin
                res.digit[1] = (quot.neg && ge10) ? fdnf_pkg::CODE_MINUS
                                                  : fdnf_pkg::CODE_BLANK;
            end
            if (ge1000)
            begin
                res.digit[0] = {4'b0000, dig0};
            end
            else
            begin
                res.digit[0] = (quot.neg && ge100) ? fdnf_pkg::CODE_MINUS
                                                   : fdnf_pkg::CODE_BLANK;
            end
        end
    end

endmodule

>>> hw/rtl/four_digit_number_formatter.sv
// Four-digit display formatter: input register, three work stages and a result register.
// A transaction passes the input, class, product, quotient and result registers in turn.
// Throughput: one transaction per cycle; each stage holds one item and moves on when
// the stage after it is empty or moving, so a stalled result does not block empty stages.
// The stage multipliers (scale by a power of ten, reciprocal division) set the stage depth.
// Reset clears all valid flags; payload registers are not reset.
module four_digit_number_formatter #(
    parameter int FRACTION_BITS = fdnf_pkg::FRACTION_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic signed [31:0]            number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fdnf_pkg::DIG_W-1:0]    digit_0,
    output logic [fdnf_pkg::DIG_W-1:0]    digit_1,
    output logic [fdnf_pkg::DIG_W-1:0]    digit_2,
    output logic [fdnf_pkg::DIG_W-1:0]    digit_3,
    output logic [3:0]                    point_mask
);

    logic               in_valid_reg;
    logic               in_type_reg;
    logic signed [31:0] in_number_reg;
    logic               cls_valid_reg;
    fdnf_pkg::cls_t     cls_reg;
    logic               prod_valid_reg;
    fdnf_pkg::prod_t    prod_reg;
    logic               quot_valid_reg;
    fdnf_pkg::quot_t    quot_reg;
    logic               out_valid_reg;
    fdnf_pkg::res_t     res_reg;

    fdnf_pkg::cls_t     cls_next;
    fdnf_pkg::prod_t    prod_next;
    fdnf_pkg::quot_t    quot_next;
    fdnf_pkg::res_t     res_next;

    logic en_out;
    logic en_quot;
    logic en_prod;
    logic en_cls;
    logic en_in;

    assign en_out   = !out_valid_reg || out_ready;
    assign en_quot  = !quot_valid_reg || en_out;
    assign en_prod  = !prod_valid_reg || en_quot;
    assign en_cls   = !cls_valid_reg || en_prod;
    assign en_in    = !in_valid_reg || en_cls;
    assign in_ready = en_in;

    fdnf_classify #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_classify (
        .req_type(in_type_reg),
        .number  (in_number_reg),
        .cls     (cls_next)
    );

    fdnf_scale #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_scale (
        .cls (cls_reg),
        .prod(prod_next)
    );

    fdnf_split #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_split (
        .prod(prod_reg),
        .quot(quot_next)
    );

    fdnf_layout u_layout (
        .quot(quot_reg),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            cls_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            quot_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en_in)
            begin
                in_valid_reg <= in_valid;
            end
            if (en_cls)
            begin
                cls_valid_reg <= in_valid_reg;
            end
            if (en_prod)
            begin
                prod_valid_reg <= cls_valid_reg;
            end
            if (en_quot)
            begin
                quot_valid_reg <= prod_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= quot_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            in_type_reg   <= req_type;
            in_number_reg <= number;
        end
        if (en_cls)
        begin
            cls_reg <= cls_next;
        end
        if (en_prod)
        begin
            prod_reg <= prod_next;
        end
        if (en_quot)
        begin
            quot_reg <= quot_next;
        end
        if (en_out)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit_0    = res_reg.digit[0];
    assign digit_1    = res_reg.digit[1];
    assign digit_2    = res_reg.digit[2];
    assign digit_3    = res_reg.digit[3];
    assign point_mask = res_reg.mask;

endmodule

>>> hw/rtl/fdnf_checker.sv
// Port-level checker for the formatter and its bind to the top level.
`include "assert_macros.svh"

module fdnf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       req_type,
    input logic signed [31:0]         number,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [fdnf_pkg::DIG_W-1:0] digit_0,
    input logic [fdnf_pkg::DIG_W-1:0] digit_1,
    input logic [fdnf_pkg::DIG_W-1:0] digit_2,
    input logic [fdnf_pkg::DIG_W-1:0] digit_3,
    input logic [3:0]                 point_mask
);

    // A stalled result transaction keeps its valid and its digits.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({digit_0, digit_1, digit_2, digit_3, point_mask}))

    // At most one decimal point is lit.
    `ASSERT_IMPLY(a_one_point, clk, rst_n, out_valid, $onehot0(point_mask))

    // The rightmost position always shows a digit.
    `ASSERT_IMPLY(a_last_digit, clk, rst_n, out_valid, digit_3 <= 8'd9)

    // With a point lit, every position holds a digit or the leading minus sign.
    `ASSERT_IMPLY(a_frac_filled, clk, rst_n, out_valid && point_mask != 4'b0000, digit_0 != fdnf_pkg::CODE_BLANK && digit_1 <= 8'd9 && digit_2 <= 8'd9)

endmodule

bind four_digit_number_formatter fdnf_checker u_fdnf_checker (.*);
